>>> design/lrs_pkg.sv
// lrs_pkg: shared widths, register codes and controller/datapath interface types
// for the stereo linear resampler. No dependencies.
package lrs_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int Q_W        = 24;   // Q1.23 internal sample
  localparam int PCM_W      = 16;
  localparam int PCM_SH     = 15;   // 32767 = 2^15 - 1
  localparam int RATE_W     = 18;
  localparam int PHASE_W    = 18;
  localparam int CHAN_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam int MIN_RATE    = 8000;
  localparam int MAX_RESULTS = 6;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int OUTPUT_RATE_DEF   = 48000;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input transaction
    logic decode;   // convert captured samples, seed previous frame
    logic step;     // advance phase one position
    logic issue;    // launch one output frame into the pipeline
    logic last;     // launched frame is the last for this item
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cfg_ok;
    logic bypass;
    logic step_emit;  // current phase lies inside this input interval
    logic step_done;  // phase leaves the interval after this step
    logic pipe_en;    // pipeline advances this cycle
  } stat_t;

endpackage

>>> design/lrs_ctrl.sv
// lrs_ctrl: sequencer for one input item at a time: capture, decode, phase steps.
// Depends on lrs_pkg (cmd_t, stat_t, MAX_RESULTS).
module lrs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lrs_pkg::stat_t stat,
  output lrs_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;

  logic [1:0]                state, state_next;
  logic [lrs_pkg::CNT_W-1:0] cnt, cnt_next;
  logic                      room;

  assign room     = cnt < lrs_pkg::CNT_W'(lrs_pkg::MAX_RESULTS);
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
        // drop the transaction when the configuration is invalid
        if (in_valid && stat.cfg_ok) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        cnt_next   = '0;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (stat.pipe_en) begin
          cmd.step = 1'b1;
          if (stat.bypass) begin
            cmd.issue  = 1'b1;
            cmd.last   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            // past the frame limit, keep stepping the phase without output
            cmd.issue = stat.step_emit && room;
            cmd.last  = stat.step_done ||
                        (cnt == lrs_pkg::CNT_W'(lrs_pkg::MAX_RESULTS - 1));
            if (cmd.issue) begin
              cnt_next = cnt + 1'b1;
            end
            if (stat.step_done) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

>>> design/lrs_dpath.sv
// lrs_dpath: sample decode, previous frame and phase state, and the frame pipeline
// (fraction by reciprocal, interpolation, PCM16 scaling, output register).
// Depends on lrs_pkg.
module lrs_dpath #(
  parameter int OUTPUT_RATE   = lrs_pkg::OUTPUT_RATE_DEF,
  parameter int FRACTION_BITS = lrs_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lrs_pkg::cmd_t                 cmd,
  output lrs_pkg::stat_t                stat,
  input  logic [lrs_pkg::RATE_W-1:0]    input_rate,
  input  logic [lrs_pkg::CHAN_W-1:0]    channel_count,
  input  logic                          sample_format,
  input  logic [lrs_pkg::SAMPLE_W-1:0]  sample_first,
  input  logic [lrs_pkg::SAMPLE_W-1:0]  sample_second,
  input  logic                          block_final,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [lrs_pkg::PCM_W-1:0] left_out,
  output logic signed [lrs_pkg::PCM_W-1:0] right_out,
  output logic                          run_last,
  output logic                          block_end
);

  localparam int QW       = lrs_pkg::Q_W;
  localparam int PW       = lrs_pkg::PHASE_W;
  localparam int FB       = FRACTION_BITS;
  localparam int ACC_W    = PW + 1;
  localparam logic [63:0] RECIP = (64'd1 << (FB + PW)) / 64'(OUTPUT_RATE);
  localparam int RECIP_W  = $clog2(RECIP + 64'd1);
  localparam int RP_W     = PW + RECIP_W;
  localparam int OUT_W    = $clog2(OUTPUT_RATE + 1);
  localparam int QO_W     = FB + OUT_W;
  localparam int REM_W    = $clog2(2 * OUTPUT_RATE);
  localparam int DIFF_W   = QW + 1;
  localparam int PROD_W   = DIFF_W + FB + 1;
  localparam int SC_W     = QW + lrs_pkg::PCM_SH;

  // float32 or int16 bits to Q1.23, rounded half away from zero, saturated
  function automatic logic [QW-1:0] decode(input logic [lrs_pkg::SAMPLE_W-1:0] raw,
                                           input logic fmt);
    logic [7:0]  expo;
    logic [6:0]  shift;
    logic [24:0] mant_f;
    logic [24:0] mag;
    logic [QW-1:0] res;
    expo   = raw[30:23];
    mant_f = {2'b01, raw[22:0]};
    shift  = 7'd127 - expo[6:0];
    mag    = '0;
    if (!fmt) begin
      res = {raw[15:0], 8'h00};
    end else if ((expo == 8'hFF && raw[22:0] != '0) || expo == 8'h00) begin
      res = '0;
    end else begin
      if (expo >= 8'd127) begin
        mag = 25'd1 << (QW - 1);
      end else if (shift > 7'd25) begin
        mag = '0;
      end else begin
        mag = (mant_f + (25'd1 << (shift - 7'd1))) >> shift;
        if (mag > (25'd1 << (QW - 1))) begin
          mag = 25'd1 << (QW - 1);
        end
      end
      if (raw[31]) begin
        res = QW'(~mag + 25'd1);
      end else if (mag > 25'((1 << (QW - 1)) - 1)) begin
        res = QW'((1 << (QW - 1)) - 1);
      end else begin
        res = mag[QW-1:0];
      end
    end
    return res;
  endfunction

  // item registers
  logic [lrs_pkg::SAMPLE_W-1:0] in_first, in_second;
  logic                         in_final;
  logic [QW-1:0]                cur [2];
  logic [QW-1:0]                prev [2];
  logic [QW-1:0]                dec [2];
  logic                         have_prev;
  logic [PW-1:0]                phase_num;
  logic [ACC_W-1:0]             ph_work, ph_adv;
  logic                         below, done, bypass, en;

  // pipeline
  logic              v1, v2, v3, v4, v5, v6;
  logic              last1, last2, last3, last4, last5, last6;
  logic              fin1, fin2, fin3, fin4, fin5, fin6;
  logic [QW-1:0]     a1 [2], b1 [2], a2 [2], b2 [2], a3 [2], b3 [2], a4 [2];
  logic [PW-1:0]     ph1, ph2;
  logic [FB-1:0]     q2, frac3, frac_c;
  logic [RP_W-1:0]   recip_prod;
  logic [QO_W-1:0]   qo;
  logic [PW+FB-1:0]  ph_sh;
  logic [REM_W-1:0]  rem;
  logic signed [DIFF_W-1:0] diff [2];
  logic signed [PROD_W-1:0] prod [2], prod4 [2], prod_sh [2];
  logic [DIFF_W-1:0] y_sum [2];
  logic [QW-1:0]     y5 [2], mag [2];
  logic [SC_W-1:0]   scaled [2], scaled6 [2], rnd [2];
  logic              neg6 [2];
  logic [lrs_pkg::PCM_W-1:0] pcm [2];

  assign bypass = (input_rate == lrs_pkg::RATE_W'(OUTPUT_RATE));
  assign en     = !out_valid || out_ready;
  assign below  = ph_work < ACC_W'(OUTPUT_RATE);
  assign ph_adv = below ? ph_work + ACC_W'(input_rate) : ph_work;
  assign done   = ph_adv >= ACC_W'(OUTPUT_RATE);

  assign stat.cfg_ok    = (input_rate >= lrs_pkg::RATE_W'(lrs_pkg::MIN_RATE)) &&
                          (channel_count != '0);
  assign stat.bypass    = bypass;
  assign stat.step_emit = below;
  assign stat.step_done = done;
  assign stat.pipe_en   = en;

  assign dec[0] = decode(in_first, sample_format);
  assign dec[1] = (channel_count == lrs_pkg::CHAN_W'(1)) ? dec[0]
                                                         : decode(in_second, sample_format);

  // fraction: estimate by reciprocal, then one correction step
  assign recip_prod = RP_W'(ph1) * RP_W'(RECIP);
  assign qo         = QO_W'(q2) * QO_W'(OUTPUT_RATE);
  assign ph_sh      = {ph2, {FB{1'b0}}};
  assign rem        = ph_sh[REM_W-1:0] - qo[REM_W-1:0];
  assign frac_c     = q2 + FB'(rem >= REM_W'(OUTPUT_RATE));

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      diff[k]    = $signed({b3[k][QW-1], b3[k]}) - $signed({a3[k][QW-1], a3[k]});
      prod[k]    = PROD_W'(diff[k]) * PROD_W'($signed({1'b0, frac3}));
      prod_sh[k] = prod4[k] >>> FB;
      y_sum[k]   = {a4[k][QW-1], a4[k]} + prod_sh[k][DIFF_W-1:0];
      mag[k]     = y5[k][QW-1] ? (~y5[k] + 1'b1) : y5[k];
      scaled[k]  = {mag[k], {lrs_pkg::PCM_SH{1'b0}}} - SC_W'(mag[k]);
      rnd[k]     = scaled6[k] + SC_W'(1 << (QW - 2));
      pcm[k]     = neg6[k] ? (~rnd[k][SC_W-1 -: lrs_pkg::PCM_W] + 1'b1)
                           : rnd[k][SC_W-1 -: lrs_pkg::PCM_W];
    end
  end

  // control state and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      phase_num <= '0;
      ph_work   <= '0;
      prev[0]   <= '0;
      prev[1]   <= '0;
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.decode) begin
        ph_work <= ACC_W'(phase_num);
        // first frame serves as its own predecessor
        if (!bypass && !have_prev) begin
          prev[0]   <= dec[0];
          prev[1]   <= dec[1];
          have_prev <= 1'b1;
        end
      end
      if (cmd.step && !bypass) begin
        ph_work <= ph_adv;
        if (done) begin
          phase_num <= PW'(ph_adv - ACC_W'(OUTPUT_RATE));
          prev[0]   <= cur[0];
          prev[1]   <= cur[1];
        end
      end
      if (en) begin
        v1 <= cmd.issue;
        v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
        out_valid <= v6;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_first  <= sample_first;
      in_second <= sample_second;
      in_final  <= block_final;
    end
    if (cmd.decode) begin
      cur[0] <= dec[0];
      cur[1] <= dec[1];
    end
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        a1[k]      <= bypass ? cur[k] : prev[k];
        b1[k]      <= cur[k];
        a2[k]      <= a1[k];
        b2[k]      <= b1[k];
        a3[k]      <= a2[k];
        b3[k]      <= b2[k];
        a4[k]      <= a3[k];
        prod4[k]   <= prod[k];
        y5[k]      <= y_sum[k][QW-1:0];
        scaled6[k] <= scaled[k];
        neg6[k]    <= y5[k][QW-1];
      end
      ph1   <= bypass ? '0 : ph_work[PW-1:0];
      ph2   <= ph1;
      q2    <= recip_prod[PW +: FB];
      frac3 <= frac_c;
      last1 <= cmd.last;
      fin1  <= in_final;
      last2 <= last1; last3 <= last2; last4 <= last3; last5 <= last4; last6 <= last5;
      fin2  <= fin1;  fin3  <= fin2;  fin4  <= fin3;  fin5  <= fin4;  fin6  <= fin5;
      left_out  <= pcm[0];
      right_out <= pcm[1];
      run_last  <= last6;
      block_end <= last6 && fin6;
    end
  end

endmodule

>>> design/linear_resampler_stereo.sv
// linear_resampler_stereo: top level with configuration registers, sequencer and
// datapath. Depends on lrs_pkg, lrs_ctrl, lrs_dpath.
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------------
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in      | in_valid / in_ready   | sample_first, sample_second, block_final
//   out     | out_valid / out_ready | left_out, right_out, run_last, block_end
//
// An item is captured, then decoded, then takes max(1, k) phase steps (held while stalled),
// k being the output positions in its input interval (steps past six emit nothing);
// bypass takes one phase step, and an item under an invalid configuration ends at capture.
// A launched frame reaches the output through six pipeline stages and the output register.
// Reset clears configuration (items dropped until written), phase and previous frame.
// Low out_ready with a frame held freezes pipeline and phase stepping; cfg_ready stays high.
module linear_resampler_stereo #(
  parameter int OUTPUT_RATE   = lrs_pkg::OUTPUT_RATE_DEF,
  parameter int FRACTION_BITS = lrs_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lrs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lrs_pkg::SAMPLE_W-1:0]    sample_first,
  input  logic [lrs_pkg::SAMPLE_W-1:0]    sample_second,
  input  logic                            block_final,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [lrs_pkg::PCM_W-1:0] left_out,
  output logic signed [lrs_pkg::PCM_W-1:0] right_out,
  output logic                            run_last,
  output logic                            block_end
);

  logic [lrs_pkg::RATE_W-1:0] input_rate;
  logic [lrs_pkg::CHAN_W-1:0] channel_count;
  logic                       sample_format;
  lrs_pkg::cmd_t              cmd;
  lrs_pkg::stat_t             stat;

  assign cfg_ready = 1'b1;

  // unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      input_rate    <= '0;
      channel_count <= '0;
      sample_format <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lrs_pkg::CFG_INPUT_RATE:    input_rate    <= cfg_data[lrs_pkg::RATE_W-1:0];
        lrs_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data[lrs_pkg::CHAN_W-1:0];
        lrs_pkg::CFG_SAMPLE_FORMAT: sample_format <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  lrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrs_dpath #(
    .OUTPUT_RATE   (OUTPUT_RATE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .input_rate    (input_rate),
    .channel_count (channel_count),
    .sample_format (sample_format),
    .sample_first  (sample_first),
    .sample_second (sample_second),
    .block_final   (block_final),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .left_out      (left_out),
    .right_out     (right_out),
    .run_last      (run_last),
    .block_end     (block_end)
  );

`ifndef ASSERT_OFF
  a_issue_moves: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> stat.pipe_en)
    else $error("frame launched while pipeline is stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && stat.cfg_ok) |=> !in_ready)
    else $error("new transaction taken while an item is in work");

  a_block_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && block_end) |-> run_last)
    else $error("block_end without run_last");
`endif

endmodule
